// ----- design/ray_cylinder_intersect_defines.svh -----
// assertion macros shared by the ray cylinder intersection modules
`ifndef RAY_CYLINDER_INTERSECT_DEFINES_SVH
`define RAY_CYLINDER_INTERSECT_DEFINES_SVH

// same-cycle implication
`define RCI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rci assertion failed");

// next-cycle implication
`define RCI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rci assertion failed");

`endif

// ----- design/rci_pkg.sv -----
// shared types and constants of the ray cylinder intersection block
package rci_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int FIFO_DEPTH    = 4;
   localparam int SQRT_STAGES   = 64;
   localparam int DIV_STAGES    = 32;

   typedef struct packed {
      logic signed [31:0] oz;
      logic signed [31:0] dz;
      logic signed [31:0] tmin;
      logic signed [31:0] tmax;
   } tail_type;

   typedef struct packed {
      logic               nohit;
      logic [63:0]        a;
      logic signed [64:0] h;
      tail_type           tail;
   } side_type;

   typedef struct packed {
      side_type     side;
      logic [127:0] d;
   } entry_type;

   typedef struct packed {
      logic valid;
      logic full;
   } q_stat_type;

endpackage

// ----- design/rci_front.sv -----
// front end: quadratic coefficients, discriminant and no-hit classification
module rci_front #(
   parameter int FRAC_BITS = rci_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic signed [31:0] in_ox,
   input  logic signed [31:0] in_oy,
   input  logic signed [31:0] in_oz,
   input  logic signed [31:0] in_dx,
   input  logic signed [31:0] in_dy,
   input  logic signed [31:0] in_dz,
   input  logic signed [31:0] in_tmin,
   input  logic signed [31:0] in_tmax,
   input  logic               q_full,
   output logic               q_push,
   output rci_pkg::entry_type q_entry
);

   localparam logic [63:0] ONE_SQ = 64'(1) << (2 * FRAC_BITS);

   logic en;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   // stage 1: captured ray
   logic signed [31:0] ox1_ff, oy1_ff, dx1_ff, dy1_ff;
   rci_pkg::tail_type  tail1_ff, tail2_ff, tail3_ff, tail4_ff, tail5_ff;
   // stage 2: products
   logic signed [63:0] dxx2_ff, dyy2_ff, dxo2_ff, dyo2_ff, oxx2_ff, oyy2_ff;
   // stage 3: coefficients
   logic [63:0]        a3_ff, a4_ff, a5_ff;
   logic signed [64:0] h3_ff, h4_ff, h5_ff;
   logic [63:0]        hmag3_ff, cmag3_ff;
   logic               cneg3_ff, cneg4_ff, cneg5_ff;
   // stage 4: partial products of h^2 and a*c
   logic [63:0]        hll4_ff, hlh4_ff, hhh4_ff;
   logic [63:0]        all4_ff, alh4_ff, ahl4_ff, ahh4_ff;
   // stage 5: full squares
   logic [127:0]       h2_5_ff, ac5_ff;

   logic [63:0]        a_w, sq_w, cmag_w;
   logic signed [64:0] h_w, hmag_w;
   logic               cneg_w;
   logic [127:0]       h2_w, ac_w;

   assign en       = !v5_ff || !q_full;
   assign in_ready = en;
   assign q_push   = v5_ff && !q_full;

   always_comb begin
      a_w    = 64'(dxx2_ff) + 64'(dyy2_ff);
      h_w    = 65'(dxo2_ff) + 65'(dyo2_ff);
      sq_w   = 64'(oxx2_ff) + 64'(oyy2_ff);
      cneg_w = sq_w < ONE_SQ;
      cmag_w = cneg_w ? (ONE_SQ - sq_w) : (sq_w - ONE_SQ);
      hmag_w = h_w[64] ? -h_w : h_w;
   end

   always_comb begin
      h2_w = (128'(hhh4_ff) << 64) + (128'(hlh4_ff) << 33) + 128'(hll4_ff);
      ac_w = (128'(ahh4_ff) << 64) + ((128'(alh4_ff) + 128'(ahl4_ff)) << 32)
           + 128'(all4_ff);
   end

   // discriminant and classification feed the queue directly
   always_comb begin
      q_entry.d          = cneg5_ff ? (h2_5_ff + ac5_ff) : (h2_5_ff - ac5_ff);
      q_entry.side.nohit = (a5_ff == 64'd0) || (!cneg5_ff && (h2_5_ff < ac5_ff));
      q_entry.side.a     = a5_ff;
      q_entry.side.h     = h5_ff;
      q_entry.side.tail  = tail5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ox1_ff         <= in_ox;
         oy1_ff         <= in_oy;
         dx1_ff         <= in_dx;
         dy1_ff         <= in_dy;
         tail1_ff.oz    <= in_oz;
         tail1_ff.dz    <= in_dz;
         tail1_ff.tmin  <= in_tmin;
         tail1_ff.tmax  <= in_tmax;

         dxx2_ff  <= 64'(dx1_ff) * 64'(dx1_ff);
         dyy2_ff  <= 64'(dy1_ff) * 64'(dy1_ff);
         dxo2_ff  <= 64'(dx1_ff) * 64'(ox1_ff);
         dyo2_ff  <= 64'(dy1_ff) * 64'(oy1_ff);
         oxx2_ff  <= 64'(ox1_ff) * 64'(ox1_ff);
         oyy2_ff  <= 64'(oy1_ff) * 64'(oy1_ff);
         tail2_ff <= tail1_ff;

         a3_ff    <= a_w;
         h3_ff    <= h_w;
         hmag3_ff <= hmag_w[63:0];
         cmag3_ff <= cmag_w;
         cneg3_ff <= cneg_w;
         tail3_ff <= tail2_ff;

         hll4_ff  <= 64'(hmag3_ff[31:0])  * 64'(hmag3_ff[31:0]);
         hlh4_ff  <= 64'(hmag3_ff[31:0])  * 64'(hmag3_ff[63:32]);
         hhh4_ff  <= 64'(hmag3_ff[63:32]) * 64'(hmag3_ff[63:32]);
         all4_ff  <= 64'(a3_ff[31:0])  * 64'(cmag3_ff[31:0]);
         alh4_ff  <= 64'(a3_ff[31:0])  * 64'(cmag3_ff[63:32]);
         ahl4_ff  <= 64'(a3_ff[63:32]) * 64'(cmag3_ff[31:0]);
         ahh4_ff  <= 64'(a3_ff[63:32]) * 64'(cmag3_ff[63:32]);
         a4_ff    <= a3_ff;
         h4_ff    <= h3_ff;
         cneg4_ff <= cneg3_ff;
         tail4_ff <= tail3_ff;

         h2_5_ff  <= h2_w;
         ac5_ff   <= ac_w;
         a5_ff    <= a4_ff;
         h5_ff    <= h4_ff;
         cneg5_ff <= cneg4_ff;
         tail5_ff <= tail4_ff;
      end
   end

endmodule

// ----- design/rci_fifo.sv -----
// short queue between the front end and the root solver
`include "ray_cylinder_intersect_defines.svh"

module rci_fifo #(
   parameter int DEPTH = rci_pkg::FIFO_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rci_pkg::entry_type  din,
   input  logic                pop,
   output rci_pkg::q_stat_type stat,
   output rci_pkg::entry_type  dout
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rci_pkg::entry_type mem [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign stat = '{valid: (cnt_ff != CW'(0)), full: (cnt_ff == CW'(DEPTH))};
   assign dout = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? AW'(0) : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? AW'(0) : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= din;
      end
   end

   `RCI_ASSERT_NEXT(a_cnt_up, clock, reset, push && !pop, cnt_ff == $past(cnt_ff) + CW'(1))
   `RCI_ASSERT_NEXT(a_cnt_down, clock, reset, pop && !push, cnt_ff == $past(cnt_ff) - CW'(1))

endmodule

// ----- design/rci_back.sv -----
// back end: pipelined square root, two dividers, z test and root selection
`include "ray_cylinder_intersect_defines.svh"

module rci_back #(
   parameter int FRAC_BITS = rci_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  rci_pkg::q_stat_type q_stat,
   input  rci_pkg::entry_type  q_entry,
   output logic                q_pop,
   output logic                out_valid,
   input  logic                out_ready,
   output logic                out_hit,
   output logic signed [31:0]  out_dist
);

   localparam int SQ = rci_pkg::SQRT_STAGES;
   localparam int DV = rci_pkg::DIV_STAGES;
   localparam int MW = 66 + FRAC_BITS;
   localparam logic signed [64:0] UNIT  = 65'sd1 <<< FRAC_BITS;
   localparam logic signed [64:0] NUNIT = -UNIT;

   logic en;

   // square root stages, one result bit each
   logic [SQ-1:0]      sq_v_ff;
   logic [127:0]       sq_rem_ff  [SQ];
   logic [127:0]       sq_rem_in  [SQ];
   logic [63:0]        sq_root_ff [SQ];
   logic [63:0]        sq_root_in [SQ];
   rci_pkg::side_type  sq_side_ff [SQ];

   // numerator setup
   logic               p_v_ff;
   rci_pkg::side_type  p_side_ff;
   logic [63:0]        p_rem_ff [2];
   logic [31:0]        p_low_ff [2];
   logic               p_ovf_ff [2];
   logic               p_neg_ff [2];
   logic [63:0]        p_rem_in [2];
   logic [31:0]        p_low_in [2];
   logic               p_ovf_in [2];
   logic               p_neg_in [2];

   // divider stages, one quotient bit each, both roots side by side
   logic [DV-1:0]      dv_v_ff;
   rci_pkg::side_type  dv_side_ff [DV];
   logic [63:0]        dv_rem_ff  [DV][2];
   logic [63:0]        dv_rem_in  [DV][2];
   logic [31:0]        dv_q_ff    [DV][2];
   logic [31:0]        dv_q_in    [DV][2];
   logic [31:0]        dv_low_ff  [DV][2];
   logic               dv_ovf_ff  [DV][2];
   logic               dv_neg_ff  [DV][2];

   // saturated roots
   logic               t_v_ff;
   rci_pkg::side_type  t_side_ff;
   logic signed [31:0] t_ff [2];
   logic signed [31:0] t_in [2];

   // z products
   logic               m_v_ff;
   rci_pkg::side_type  m_side_ff;
   logic signed [31:0] m_t_ff    [2];
   logic signed [63:0] m_prod_ff [2];
   logic               m_gt_ff   [2];

   // result register
   logic               o_v_ff;
   logic               o_hit_ff, o_hit_in;
   logic signed [31:0] o_dist_ff, o_dist_in;

   assign en        = !o_v_ff || out_ready;
   assign q_pop     = en && q_stat.valid;
   assign out_valid = o_v_ff;
   assign out_hit   = o_hit_ff;
   assign out_dist  = o_dist_ff;

   always_comb begin
      logic [127:0] rs;
      logic [127:0] trial;
      logic [63:0]  ro;
      for (int i = 0; i < SQ; i++) begin
         if (i == 0) begin
            rs = q_entry.d;
            ro = '0;
         end else begin
            rs = sq_rem_ff[i-1];
            ro = sq_root_ff[i-1];
         end
         // (2r + 2^b) * 2^b, r holds only bits above b
         trial = (128'(ro) << (SQ - i)) | (128'd1 << (2 * (SQ - 1 - i)));
         if (rs >= trial) begin
            sq_rem_in[i]  = rs - trial;
            sq_root_in[i] = ro | (64'd1 << (SQ - 1 - i));
         end else begin
            sq_rem_in[i]  = rs;
            sq_root_in[i] = ro;
         end
      end
   end

   always_comb begin
      logic signed [66:0] hx;
      logic signed [66:0] sx;
      logic signed [66:0] n;
      logic signed [66:0] mag;
      logic [MW-1:0]      mfull;
      logic [127:0]       hi;
      hx = 67'(sq_side_ff[SQ-1].h);
      sx = $signed({3'b000, sq_root_ff[SQ-1]});
      for (int r = 0; r < 2; r++) begin
         n           = (r == 0) ? (-hx - sx) : (-hx + sx);
         mag         = n[66] ? -n : n;
         mfull       = MW'(mag[65:0]) << FRAC_BITS;
         hi          = 128'(mfull >> 32);
         p_ovf_in[r] = hi >= 128'(sq_side_ff[SQ-1].a);
         p_rem_in[r] = hi[63:0];
         p_low_in[r] = mfull[31:0];
         p_neg_in[r] = n[66];
      end
   end

   always_comb begin
      logic [63:0] rs;
      logic [31:0] lo;
      logic [31:0] qs;
      logic [63:0] av;
      logic [64:0] rem2;
      logic        ge;
      for (int j = 0; j < DV; j++) begin
         for (int r = 0; r < 2; r++) begin
            if (j == 0) begin
               rs = p_rem_ff[r];
               lo = p_low_ff[r];
               qs = '0;
               av = p_side_ff.a;
            end else begin
               rs = dv_rem_ff[j-1][r];
               lo = dv_low_ff[j-1][r];
               qs = dv_q_ff[j-1][r];
               av = dv_side_ff[j-1].a;
            end
            rem2 = {rs, lo[DV-1-j]};
            ge   = rem2 >= {1'b0, av};
            dv_rem_in[j][r] = ge ? 64'(rem2 - {1'b0, av}) : rem2[63:0];
            dv_q_in[j][r]   = {qs[30:0], ge};
         end
      end
   end

   always_comb begin
      logic [31:0] q;
      for (int r = 0; r < 2; r++) begin
         q = dv_q_ff[DV-1][r];
         if (dv_ovf_ff[DV-1][r] || q[31]) begin
            t_in[r] = dv_neg_ff[DV-1][r] ? 32'sh8000_0000 : 32'sh7fff_ffff;
         end else begin
            t_in[r] = dv_neg_ff[DV-1][r] ? -$signed(q) : $signed(q);
         end
      end
   end

   always_comb begin
      logic signed [64:0] z;
      logic               ok [2];
      for (int r = 0; r < 2; r++) begin
         z     = 65'(m_side_ff.tail.oz) + 65'(m_prod_ff[r] >>> FRAC_BITS);
         ok[r] = m_gt_ff[r] && (z >= NUNIT) && (z <= UNIT);
      end
      // first root in range wins, the second is tried only if the first fails
      o_hit_in  = !m_side_ff.nohit &&
                  (ok[0] ? (m_t_ff[0] < m_side_ff.tail.tmax)
                         : (ok[1] && (m_t_ff[1] < m_side_ff.tail.tmax)));
      o_dist_in = o_hit_in ? (ok[0] ? m_t_ff[0] : m_t_ff[1]) : 32'sd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff <= '0;
         p_v_ff  <= 1'b0;
         dv_v_ff <= '0;
         t_v_ff  <= 1'b0;
         m_v_ff  <= 1'b0;
         o_v_ff  <= 1'b0;
      end else if (en) begin
         sq_v_ff <= {sq_v_ff[SQ-2:0], q_stat.valid};
         p_v_ff  <= sq_v_ff[SQ-1];
         dv_v_ff <= {dv_v_ff[DV-2:0], p_v_ff};
         t_v_ff  <= dv_v_ff[DV-1];
         m_v_ff  <= t_v_ff;
         o_v_ff  <= m_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < SQ; i++) begin
            sq_rem_ff[i]  <= sq_rem_in[i];
            sq_root_ff[i] <= sq_root_in[i];
            sq_side_ff[i] <= (i == 0) ? q_entry.side : sq_side_ff[i-1];
         end
         p_side_ff <= sq_side_ff[SQ-1];
         for (int r = 0; r < 2; r++) begin
            p_rem_ff[r] <= p_rem_in[r];
            p_low_ff[r] <= p_low_in[r];
            p_ovf_ff[r] <= p_ovf_in[r];
            p_neg_ff[r] <= p_neg_in[r];
         end
         for (int j = 0; j < DV; j++) begin
            dv_side_ff[j] <= (j == 0) ? p_side_ff : dv_side_ff[j-1];
            for (int r = 0; r < 2; r++) begin
               dv_rem_ff[j][r] <= dv_rem_in[j][r];
               dv_q_ff[j][r]   <= dv_q_in[j][r];
               dv_low_ff[j][r] <= (j == 0) ? p_low_ff[r] : dv_low_ff[j-1][r];
               dv_ovf_ff[j][r] <= (j == 0) ? p_ovf_ff[r] : dv_ovf_ff[j-1][r];
               dv_neg_ff[j][r] <= (j == 0) ? p_neg_ff[r] : dv_neg_ff[j-1][r];
            end
         end
         t_side_ff <= dv_side_ff[DV-1];
         m_side_ff <= t_side_ff;
         for (int r = 0; r < 2; r++) begin
            t_ff[r]      <= t_in[r];
            m_t_ff[r]    <= t_ff[r];
            m_prod_ff[r] <= 64'(t_ff[r]) * 64'(t_side_ff.tail.dz);
            m_gt_ff[r]   <= t_ff[r] > t_side_ff.tail.tmin;
         end
         o_hit_ff  <= o_hit_in;
         o_dist_ff <= o_dist_in;
      end
   end

   `RCI_ASSERT_NEXT(a_out_hold, clock, reset, o_v_ff && !out_ready, o_v_ff)
   `RCI_ASSERT_SAME(a_miss_zero, clock, reset, o_v_ff && !o_hit_ff, o_dist_ff == 32'sd0)

endmodule

// ----- design/ray_cylinder_intersect.sv -----
// top level of the ray against canonical cylinder side intersection block
//
// req_ carries one ray per transfer (origin, direction, min and max distance,
// all signed fixed point with FRAC_BITS fraction bits); rsp_ returns exactly
// one result per ray, in order: rsp_hit and the saturated rsp_hit_dist.
// Both channels are valid/ready; a transfer happens when valid and ready are
// high at a rising clock edge.
// Throughput is one ray per cycle when nothing stalls. From the req_
// transfer to rsp_valid a ray passes 5 front stages for the
// coefficients and discriminant, one queue slot, 64 square root stages,
// one numerator stage, 32 divider stages and 3 stages for saturation,
// the z test and the result register.
// When rsp_ready is low with a result pending, the result register and the
// whole back pipeline hold; the front end keeps taking rays until the
// 4-entry queue fills and the last front stage holds a ray, then req_ready drops.
// Synchronous reset clears all valid state; no result is pending after it
// and req_ready is high in the first cycle after reset.
module ray_cylinder_intersect #(
   parameter int FRAC_BITS = rci_pkg::FRAC_BITS_DEF,
   parameter int FIFO_DEPTH = rci_pkg::FIFO_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [31:0] req_origin_z,
   input  logic signed [31:0] req_dir_x,
   input  logic signed [31:0] req_dir_y,
   input  logic signed [31:0] req_dir_z,
   input  logic signed [31:0] req_min_dist,
   input  logic signed [31:0] req_max_dist,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_hit_dist
);

   logic                q_push, q_pop;
   rci_pkg::entry_type  q_in, q_out;
   rci_pkg::q_stat_type q_stat;

   rci_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .in_ox    (req_origin_x),
      .in_oy    (req_origin_y),
      .in_oz    (req_origin_z),
      .in_dx    (req_dir_x),
      .in_dy    (req_dir_y),
      .in_dz    (req_dir_z),
      .in_tmin  (req_min_dist),
      .in_tmax  (req_max_dist),
      .q_full   (q_stat.full),
      .q_push   (q_push),
      .q_entry  (q_in)
   );

   rci_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_in),
      .pop   (q_pop),
      .stat  (q_stat),
      .dout  (q_out)
   );

   rci_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_entry   (q_out),
      .q_pop     (q_pop),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_hit   (rsp_hit),
      .out_dist  (rsp_hit_dist)
   );

endmodule

// ----- dv/ray_cylinder_intersect_tb.sv -----
// testbench for ray_cylinder_intersect: directed and randomized rays checked against an in-bench predictor
`timescale 1ns / 1ps

module ray_cylinder_intersect_tb;

   localparam int FB        = 16;
   localparam int WD_LIMIT  = 20000;
   localparam int DRAIN_CYC = 150;

   typedef struct {
      logic signed [31:0] ox, oy, oz, dx, dy, dz, tmin, tmax;
   } ray_type;

   typedef struct {
      logic               hit;
      logic signed [31:0] hit_dist;
   } isect_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_origin_x = '0, req_origin_y = '0, req_origin_z = '0;
   logic signed [31:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic signed [31:0] req_min_dist = '0, req_max_dist = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_hit;
   logic signed [31:0] rsp_hit_dist;

   ray_cylinder_intersect u_top (.*);

   ray_type   ray_q[$];
   isect_type isect_q[$];
   int     send_idle_pct = 0;
   int     recv_stall_pct = 0;
   int     n_fail = 0;
   int     n_sent = 0;
   int     n_recv = 0;
   int     n_hits = 0;
   int     idle_cyc = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   // exact integer floor sqrt of a 128-bit value
   function automatic logic [63:0] isqrt128(input logic [127:0] v);
      logic [63:0] r;
      logic [63:0] cand;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         cand = r | (64'd1 << b);
         if ({64'd0, cand} * {64'd0, cand} <= v)
            r = cand;
      end
      return r;
   endfunction

   // signed root numerator over a, scaled by 2^FB, truncated and saturated
   function automatic logic signed [63:0] root_sat(input logic signed [66:0] num,
                                                  input logic [63:0] a);
      logic [130:0] mag;
      logic [130:0] q;
      mag = num < 0 ? 131'(-num) : 131'(num);
      q = (mag << FB) / {67'd0, a};
      if (num < 0)
         return (q > 131'h80000000) ? -64'sh80000000 : -$signed(64'(q));
      return (q > 131'h7FFFFFFF) ? 64'sh7FFFFFFF : $signed(64'(q));
   endfunction

   function automatic isect_type cylinder_hit(input ray_type r);
      isect_type          res;
      logic [63:0]        a;
      logic signed [66:0] h, c;
      logic signed [131:0] disc;
      logic [63:0]        s;
      logic signed [63:0] t, z, unit;
      unit = 64'sd1 <<< FB;
      res.hit = 1'b0;
      res.hit_dist = '0;
      a = 64'(64'sd0 + r.dx * r.dx) + 64'(64'sd0 + r.dy * r.dy);
      if (a == 0)
         return res;
      h = 67'(64'sd0 + r.dx * r.ox) + 67'(64'sd0 + r.dy * r.oy);
      c = 67'(64'sd0 + r.ox * r.ox) + 67'(64'sd0 + r.oy * r.oy) - (67'sd1 <<< (2 * FB));
      disc = 132'(h) * 132'(h) - 132'(c) * $signed({68'd0, a});
      if (disc < 0)
         return res;
      s = isqrt128(128'(disc));
      for (int k = 0; k < 2; k++) begin
         t = root_sat(k == 0 ? -h - $signed({3'd0, s}) : -h + $signed({3'd0, s}), a);
         if (t <= r.tmin)
            continue;
         z = r.oz + ((t * r.dz) >>> FB);
         if (z >= -unit && z <= unit) begin
            res.hit = t < r.tmax;
            if (res.hit)
               res.hit_dist = t[31:0];
            break;
         end
      end
      return res;
   endfunction

   function automatic logic signed [31:0] rnd_val();
      case ($urandom_range(0, 3))
         0: return $signed($urandom);
         1: return $signed($urandom_range(0, 5 << FB)) - (32'sd5 <<< (FB - 1));
         2: return $signed($urandom_range(0, 1 << (FB + 1))) - (32'sd1 <<< FB);
         default: return $signed($urandom_range(0, 3 << FB)) - (32'sd3 <<< (FB - 1));
      endcase
   endfunction

   task automatic push_ray(input logic signed [31:0] ox, oy, oz, dx, dy, dz, tmin, tmax);
      ray_type r;
      r.ox = ox; r.oy = oy; r.oz = oz; r.dx = dx; r.dy = dy; r.dz = dz;
      r.tmin = tmin; r.tmax = tmax;
      ray_q.push_back(r);
   endtask

   bit xfer_req;
   always @(posedge clock) begin
      xfer_req <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         ray_type r;
         r.ox = req_origin_x; r.oy = req_origin_y; r.oz = req_origin_z;
         r.dx = req_dir_x; r.dy = req_dir_y; r.dz = req_dir_z;
         r.tmin = req_min_dist; r.tmax = req_max_dist;
         isect_q.push_back(cylinder_hit(r));
         n_sent++;
      end
   end

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || xfer_req) begin
            if (ray_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               ray_type r;
               r = ray_q.pop_front();
               req_valid <= 1'b1;
               req_origin_x <= r.ox; req_origin_y <= r.oy; req_origin_z <= r.oz;
               req_dir_x <= r.dx; req_dir_y <= r.dy; req_dir_z <= r.dz;
               req_min_dist <= r.tmin; req_max_dist <= r.tmax;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= $urandom_range(0, 99) >= recv_stall_pct;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         isect_type e;
         n_recv++;
         if (isect_q.size() == 0) begin
            $display("%0t: unexpected result hit=%0b dist=%0d", $time, rsp_hit, rsp_hit_dist);
            n_fail++;
         end else begin
            e = isect_q.pop_front();
            if (e.hit) n_hits++;
            if (rsp_hit !== e.hit || rsp_hit_dist !== e.hit_dist) begin
               $display("%0t: expected hit=%0b dist=%0d, actual hit=%0b dist=%0d",
                        $time, e.hit, e.hit_dist, rsp_hit, rsp_hit_dist);
               n_fail++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cyc <= 0;
      else if (ray_q.size() > 0 || req_valid || isect_q.size() > 0) begin
         idle_cyc <= idle_cyc + 1;
         if (idle_cyc >= WD_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("ray_cylinder_intersect: mismatch");
            $finish;
         end
      end
   end

   task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         logic signed [31:0] ox, oy;
         ox = rnd_val(); oy = rnd_val();
         if ($urandom_range(0, 9) < 7)
            // aim near the cylinder from outside or inside
            push_ray(ox, oy, rnd_val(), rnd_val(), rnd_val(), rnd_val(),
                     $urandom_range(0, 3) == 0 ? rnd_val() : 32'sd0,
                     $urandom_range(0, 3) == 0 ? rnd_val() : 32'sh7FFFFFFF);
         else
            push_ray($signed($urandom), $signed($urandom), $signed($urandom),
                     $signed($urandom), $signed($urandom), $signed($urandom),
                     $signed($urandom), $signed($urandom));
      end
      while (ray_q.size() > 0 || req_valid)
         @(posedge clock);
   endtask

   initial begin
      localparam logic signed [31:0] ONE = 32'sd1 <<< FB;
      localparam logic signed [31:0] MAXV = 32'sh7FFFFFFF;
      localparam logic signed [31:0] MINV = 32'sh80000000;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // directed: hit from outside, from inside, parallel, miss, tangent, caps, extremes
      push_ray(-2 * ONE, 0, 0, ONE, 0, 0, 0, MAXV);
      push_ray(0, 0, 0, ONE, 0, 0, 0, MAXV);
      push_ray(0, 0, 0, 0, 0, ONE, 0, MAXV);
      push_ray(ONE / 2, 0, 0, 0, 0, MAXV, MINV, MAXV);
      push_ray(-2 * ONE, 2 * ONE, 0, ONE, 0, 0, 0, MAXV);
      push_ray(-2 * ONE, ONE, 0, ONE, 0, 0, 0, MAXV);
      push_ray(-2 * ONE, 0, 0, ONE, 0, ONE, 0, MAXV);
      push_ray(-2 * ONE, 0, 2 * ONE, ONE, 0, 0, 0, MAXV);
      push_ray(-2 * ONE, 0, 0, ONE, 0, 0, ONE, 2 * ONE);
      push_ray(-2 * ONE, 0, 0, ONE, 0, 0, 0, ONE);
      push_ray(-2 * ONE, 0, 0, ONE, 0, 0, MINV, MINV);
      push_ray(-2 * ONE, 0, 0, 1, 0, 0, 0, MAXV);
      push_ray(2 * ONE, 0, 0, -1, 0, 0, MINV, MAXV);
      push_ray(0, 0, 0, 1, 1, 0, MINV, MAXV);
      push_ray(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
      push_ray(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV);
      push_ray(MINV, MAXV, -1, MAXV, MINV, -1, -1, -1);
      push_ray(-1, -1, 0, MINV, 0, 0, MINV, MAXV);
      push_ray(-ONE, 0, 0, 0, ONE, 0, MINV, MAXV);
      push_ray(0, 0, 0, ONE, ONE, 0, 0, MAXV);
      run_phase(0, 0, 0);
      run_phase(0, 0, 110);
      run_phase(50, 0, 110);
      run_phase(0, 50, 110);
      run_phase(21, 21, 120);
      run_phase(0, 0, 0);
      while (isect_q.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
      $display("covered %0d rays across four idle and stall mixes, %0d results, %0d hits",
               n_sent, n_recv, n_hits);
      if (n_fail == 0 && isect_q.size() == 0)
         $display("ray_cylinder_intersect: match");
      else
         $display("ray_cylinder_intersect: mismatch");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+design
design/rci_pkg.sv
design/rci_front.sv
design/rci_fifo.sv
design/rci_back.sv
design/ray_cylinder_intersect.sv
dv/ray_cylinder_intersect_tb.sv
